### design/sorted_base32_block_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// sorted base32 block decoder assertion macros
// clocked assertion helpers used by the decoder core
// ----------------------------------------------------------------------------
`ifndef SORTED_BASE32_BLOCK_DECODER_CORE_MACROS_SVH
`define SORTED_BASE32_BLOCK_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every clock edge, held off while in reset
`define SBD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked at every clock edge, reset included
`define SBD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SBD_ASSERT(label, clk, rst_n, prop, msg)
`define SBD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### design/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg
// types, constants and the alphabet lookup of the block decoder
// ----------------------------------------------------------------------------
`default_nettype none

package sbd_pkg;

    localparam int LANES      = 8;
    localparam int CHAR_W     = 8;
    localparam int SYM_W      = 5;
    localparam int DATA_W     = LANES * SYM_W;
    localparam int COUNT_W    = 4;
    localparam int MAX_BLOCKS = 12;

    localparam logic [CHAR_W-1:0] INVALID_CODE = 8'd255;
    localparam logic [CHAR_W-1:0] STICKY_BITS  = 8'd224;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_LENGTH  = 2'd2;

    typedef struct packed {
        logic             invalid;
        logic [SYM_W-1:0] value;
    } t_lane;

    typedef struct packed {
        logic       bad;
        logic [1:0] status;
        logic       last;
    } t_flags;

    // sorted alphabet: 3..9 then A..Y
    function automatic t_lane char_lookup(input logic [CHAR_W-1:0] c);
        t_lane res;
        res.invalid = 1'b0;
        res.value   = '0;
        if (c inside {[8'h33:8'h39]}) begin
            res.value = SYM_W'(c - 8'h33);
        end else if (c inside {[8'h41:8'h59]}) begin
            res.value = SYM_W'(c - 8'h41 + 8'd7);
        end else begin
            res.invalid = 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### design/sbd_lane.sv
// ----------------------------------------------------------------------------
// sbd_lane
// one character lane: maps a raw byte to its 5-bit symbol and invalid flag
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_lane (
    input  wire logic [sbd_pkg::CHAR_W-1:0] i_char,
    output sbd_pkg::t_lane                  o_lane
);

    assign o_lane = sbd_pkg::char_lookup(i_char);

endmodule

`default_nettype wire

### design/sbd_merge.sv
// ----------------------------------------------------------------------------
// sbd_merge
// combines lane symbols into the 40-bit word, keeps the per-id sticky flag
// and block counter, and forms the final status
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_merge #(
    parameter int MAX_BLOCKS = sbd_pkg::MAX_BLOCKS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire sbd_pkg::t_lane              i_lanes [sbd_pkg::LANES],
    input  wire logic                        i_last,
    output logic [sbd_pkg::DATA_W-1:0]       o_data,
    output sbd_pkg::t_flags                  o_flags
);

    localparam int WIDE_W = sbd_pkg::DATA_W + sbd_pkg::CHAR_W;

    logic                              r_sticky;
    logic [sbd_pkg::COUNT_W-1:0]       r_count;
    logic                              n_sticky;
    logic [sbd_pkg::COUNT_W-1:0]       n_count;
    logic [sbd_pkg::LANES:0]           carry;
    logic [sbd_pkg::CHAR_W-1:0]        sym [sbd_pkg::LANES];
    logic [WIDE_W-1:0]                 wide;
    logic                              too_long;

    // once an invalid char is seen, every later char carries the sticky bits
    always_comb begin
        carry[0] = r_sticky;
        wide     = '0;
        for (int i = 0; i < sbd_pkg::LANES; i++) begin
            sym[i] = i_lanes[i].invalid ? sbd_pkg::INVALID_CODE
                                        : sbd_pkg::CHAR_W'(i_lanes[i].value);
            if (carry[i]) begin
                sym[i] = sym[i] | sbd_pkg::STICKY_BITS;
            end
            carry[i+1] = carry[i] | i_lanes[i].invalid;
            wide = wide | (WIDE_W'(sym[i]) << (sbd_pkg::SYM_W * (sbd_pkg::LANES - 1 - i)));
        end
    end

    assign o_data   = wide[sbd_pkg::DATA_W-1:0];
    assign too_long = r_count >= sbd_pkg::COUNT_W'(MAX_BLOCKS);

    always_comb begin
        o_flags.bad  = carry[sbd_pkg::LANES];
        o_flags.last = i_last;
        if (!i_last) begin
            o_flags.status = sbd_pkg::STATUS_OK;
        end else if (too_long) begin
            o_flags.status = sbd_pkg::STATUS_LENGTH;
        end else if (carry[sbd_pkg::LANES]) begin
            o_flags.status = sbd_pkg::STATUS_INVALID;
        end else begin
            o_flags.status = sbd_pkg::STATUS_OK;
        end
    end

    always_comb begin
        n_sticky = r_sticky;
        n_count  = r_count;
        if (i_fire) begin
            if (i_last) begin
                n_sticky = 1'b0;
                n_count  = '0;
            end else begin
                n_sticky = carry[sbd_pkg::LANES];
                if (r_count != '1) begin
                    n_count = r_count + sbd_pkg::COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sticky <= 1'b0;
            r_count  <= '0;
        end else begin
            r_sticky <= n_sticky;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### design/sorted_base32_block_decoder_core.sv
// pipeline: input accept -> lane register -> output register -> result valid
// throughput: one block per cycle unless stalled; eight parallel lookup lanes
// validate mode: blocks other than the last are consumed and give no word
// reset: synchronous active low; clears the sticky flag, block counter, valid bits
// and the validate_only register
// ----------------------------------------------------------------------------
// sorted_base32_block_decoder_core
// decodes 8-character blocks of an id into 40-bit words with length and
// character checks
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_base32_block_decoder_core_macros.svh"

module sorted_base32_block_decoder_core #(
    parameter int MAX_BLOCKS = sbd_pkg::MAX_BLOCKS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [sbd_pkg::CHAR_W-1:0]    i_ch0,
    input  wire logic [sbd_pkg::CHAR_W-1:0]    i_ch1,
    input  wire logic [sbd_pkg::CHAR_W-1:0]    i_ch2,
    input  wire logic [sbd_pkg::CHAR_W-1:0]    i_ch3,
    input  wire logic [sbd_pkg::CHAR_W-1:0]    i_ch4,
    input  wire logic [sbd_pkg::CHAR_W-1:0]    i_ch5,
    input  wire logic [sbd_pkg::CHAR_W-1:0]    i_ch6,
    input  wire logic [sbd_pkg::CHAR_W-1:0]    i_ch7,
    input  wire logic                          i_last_block,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [sbd_pkg::DATA_W-1:0]         o_data_out,
    output logic                               o_bad_so_far,
    output logic [1:0]                         o_status,
    output logic                               o_is_last
);

    logic [sbd_pkg::CHAR_W-1:0]   chars [sbd_pkg::LANES];
    sbd_pkg::t_lane               lanes [sbd_pkg::LANES];
    sbd_pkg::t_lane               r_lanes [sbd_pkg::LANES];
    logic                         r_s1_valid;
    logic                         r_s1_last;
    logic                         r_out_valid;
    logic                         r_validate_only;
    logic [sbd_pkg::DATA_W-1:0]   r_data;
    sbd_pkg::t_flags              r_flags;
    logic [sbd_pkg::DATA_W-1:0]   merge_data;
    sbd_pkg::t_flags              merge_flags;
    logic                         out_free;
    logic                         s1_fire;
    logic                         in_fire;
    logic                         emit;

    assign chars[0] = i_ch0;
    assign chars[1] = i_ch1;
    assign chars[2] = i_ch2;
    assign chars[3] = i_ch3;
    assign chars[4] = i_ch4;
    assign chars[5] = i_ch5;
    assign chars[6] = i_ch6;
    assign chars[7] = i_ch7;

    for (genvar g = 0; g < sbd_pkg::LANES; g++) begin : g_lane
        sbd_lane u_lane (
            .i_char (chars[g]),
            .o_lane (lanes[g])
        );
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_fire    = i_in_valid && o_in_ready;
    // in validate mode only the last block of an id produces a word
    assign emit       = !r_validate_only || r_s1_last;

    sbd_merge #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_lanes (r_lanes),
        .i_last  (r_s1_last),
        .o_data  (merge_data),
        .o_flags (merge_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_validate_only <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_validate_only <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= s1_fire && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_lanes   <= lanes;
            r_s1_last <= i_last_block;
        end
        if (s1_fire) begin
            r_data  <= r_validate_only ? '0 : merge_data;
            r_flags <= merge_flags;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_out   = r_data;
    assign o_bad_so_far = r_flags.bad;
    assign o_status     = r_flags.status;
    assign o_is_last    = r_flags.last;

    `SBD_ASSERT(a_status_legal, i_clk, i_rst_n,
        o_out_valid |-> (o_status != 2'd3),
        "status code out of range")
    `SBD_ASSERT(a_status_only_last, i_clk, i_rst_n,
        (o_out_valid && !o_is_last) |-> (o_status == sbd_pkg::STATUS_OK),
        "status set on a word that is not last")
    `SBD_ASSERT(a_invalid_has_bad, i_clk, i_rst_n,
        (o_out_valid && o_status == sbd_pkg::STATUS_INVALID) |-> o_bad_so_far,
        "invalid status without bad flag")
    `SBD_ASSERT(a_validate_last_only, i_clk, i_rst_n,
        (o_out_valid && r_validate_only) |-> (o_is_last && o_data_out == '0),
        "validate mode word is not a clean last word")
    `SBD_ASSERT_ALWAYS(a_reset_clears, i_clk,
        !i_rst_n |=> (!o_out_valid && o_in_ready),
        "valid bits not cleared by reset")

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted base32 block decoder: directed and
// random ids are streamed through the valid/ready ports with random stalls on
// both sides, and every output word is compared with a local prediction
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAR_W     = sbd_pkg::CHAR_W;
    localparam int DATA_W     = sbd_pkg::DATA_W;
    localparam int SYM_W      = sbd_pkg::SYM_W;
    localparam int MAX_BLOCKS = sbd_pkg::MAX_BLOCKS;

    localparam logic [CHAR_W-1:0] INVALID_CODE = sbd_pkg::INVALID_CODE;
    localparam logic [CHAR_W-1:0] STICKY_BITS  = sbd_pkg::STICKY_BITS;

    localparam logic [1:0] STATUS_OK      = sbd_pkg::STATUS_OK;
    localparam logic [1:0] STATUS_INVALID = sbd_pkg::STATUS_INVALID;
    localparam logic [1:0] STATUS_LENGTH  = sbd_pkg::STATUS_LENGTH;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES = 6;

    typedef logic [7:0][CHAR_W-1:0] t_block;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              bad;
        logic [1:0]        status;
        logic              last;
    } t_decoded_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_wdata = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [CHAR_W-1:0] i_ch0 = '0;
    logic [CHAR_W-1:0] i_ch1 = '0;
    logic [CHAR_W-1:0] i_ch2 = '0;
    logic [CHAR_W-1:0] i_ch3 = '0;
    logic [CHAR_W-1:0] i_ch4 = '0;
    logic [CHAR_W-1:0] i_ch5 = '0;
    logic [CHAR_W-1:0] i_ch6 = '0;
    logic [CHAR_W-1:0] i_ch7 = '0;
    logic              i_last_block = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [DATA_W-1:0] o_data_out;
    logic              o_bad_so_far;
    logic [1:0]        o_status;
    logic              o_is_last;

    sorted_base32_block_decoder_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_ch0        (i_ch0),
        .i_ch1        (i_ch1),
        .i_ch2        (i_ch2),
        .i_ch3        (i_ch3),
        .i_ch4        (i_ch4),
        .i_ch5        (i_ch5),
        .i_ch6        (i_ch6),
        .i_ch7        (i_ch7),
        .i_last_block (i_last_block),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_data_out   (o_data_out),
        .o_bad_so_far (o_bad_so_far),
        .o_status     (o_status),
        .o_is_last    (o_is_last)
    );

    // predictor state
    logic          validate_mode = 1'b0;
    logic          id_bad = 1'b0;
    logic [3:0]    id_blocks = '0;
    t_decoded_word expected_words[$];
    t_decoded_word want_word;

    int unsigned err_count = 0;
    int unsigned idle_cycles = 0;
    bit          quiet = 1'b0;
    int unsigned hold_req = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic logic [CHAR_W-1:0] symbol_of(input logic [CHAR_W-1:0] c);
        if (c >= 8'h33 && c <= 8'h39) begin
            return c - 8'h33;
        end else if (c >= 8'h41 && c <= 8'h59) begin
            return c - 8'h41 + 8'd7;
        end
        return INVALID_CODE;
    endfunction

    function automatic logic [CHAR_W-1:0] alphabet_char(input int idx);
        return (idx < 7) ? CHAR_W'(8'h33 + idx) : CHAR_W'(8'h41 + idx - 7);
    endfunction

    function automatic void predict_block(input t_block blk, input logic last);
        logic [63:0]       pack;
        logic [CHAR_W-1:0] carry;
        logic [CHAR_W-1:0] sym;
        logic              too_long;
        t_decoded_word     w;
        pack = '0;
        carry = id_bad ? STICKY_BITS : '0;
        too_long = id_blocks >= 4'(MAX_BLOCKS);
        for (int k = 0; k < 8; k++) begin
            // once bad, every later lane carries the sticky bits
            sym = symbol_of(blk[k]) | carry;
            carry = sym & STICKY_BITS;
            pack = (pack << SYM_W) | {56'b0, sym};
        end
        w.bad = (carry != '0);
        w.last = last;
        w.status = STATUS_OK;
        if (last) begin
            if (too_long) begin
                w.status = STATUS_LENGTH;
            end else if (w.bad) begin
                w.status = STATUS_INVALID;
            end
            id_bad = 1'b0;
            id_blocks = '0;
        end else begin
            id_bad = w.bad;
            if (id_blocks != 4'hF) begin
                id_blocks = id_blocks + 4'd1;
            end
        end
        w.data = validate_mode ? '0 : pack[DATA_W-1:0];
        if (!validate_mode || last) begin
            expected_words.push_back(w);
        end
    endfunction

    // checks each output word, then predicts from the accepted input word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            validate_mode = 1'b0;
            id_bad = 1'b0;
            id_blocks = '0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("word with nothing expected", o_data_out, '0);
                end else begin
                    want_word = expected_words.pop_front();
                    if (o_data_out !== want_word.data)
                        report_mismatch("data_out", o_data_out, want_word.data);
                    if (o_bad_so_far !== want_word.bad)
                        report_mismatch("bad_so_far", DATA_W'(o_bad_so_far),
                                        DATA_W'(want_word.bad));
                    if (o_status !== want_word.status)
                        report_mismatch("status", DATA_W'(o_status),
                                        DATA_W'(want_word.status));
                    if (o_is_last !== want_word.last)
                        report_mismatch("is_last", DATA_W'(o_is_last),
                                        DATA_W'(want_word.last));
                end
            end
            if (i_cfg_we) begin
                validate_mode = i_cfg_wdata;
            end
            if (i_in_valid && o_in_ready) begin
                predict_block({i_ch7, i_ch6, i_ch5, i_ch4, i_ch3, i_ch2, i_ch1, i_ch0},
                              i_last_block);
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_block(input t_block blk, input logic last);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_ch0 <= blk[0];
        i_ch1 <= blk[1];
        i_ch2 <= blk[2];
        i_ch3 <= blk[3];
        i_ch4 <= blk[4];
        i_ch5 <= blk[5];
        i_ch6 <= blk[6];
        i_ch7 <= blk[7];
        i_last_block <= last;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        // in validate mode the last accepted word may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_validate_mode(input logic mode);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] random_char(input int bad_pct);
        if ($urandom_range(0, 99) < bad_pct) begin
            return CHAR_W'($urandom_range(0, 255));
        end
        return alphabet_char($urandom_range(0, 31));
    endfunction

    task automatic send_id(input int n_blocks, input int bad_pct);
        t_block blk;
        for (int b = 0; b < n_blocks; b++) begin
            for (int k = 0; k < 8; k++) begin
                blk[k] = random_char(bad_pct);
            end
            send_block(blk, b == n_blocks - 1);
        end
    endtask

    task automatic test_alphabet();
        t_block blk;
        for (int b = 0; b < 4; b++) begin
            for (int k = 0; k < 8; k++) begin
                blk[k] = alphabet_char(b * 8 + k);
            end
            send_block(blk, b == 3);
        end
    endtask

    task automatic test_bad_chars();
        t_block blk;
        // neighbors of both alphabet ranges plus the byte extremes
        blk = {8'h33, 8'hFF, 8'h61, 8'h5A, 8'h40, 8'h3A, 8'h32, 8'h00};
        send_block(blk, 1'b1);
        // invalid in the last lane, sticky into the following block
        blk = {8'h59, 8'h41, 8'h39, 8'h33, 8'h4B, 8'h50, 8'h36, 8'h38};
        send_block(blk, 1'b0);
        blk[7] = 8'h80;
        send_block(blk, 1'b0);
        blk[7] = 8'h59;
        send_block(blk, 1'b1);
        // invalid in the first lane of a two block id
        blk[0] = 8'h7F;
        send_block(blk, 1'b0);
        blk[0] = 8'h38;
        send_block(blk, 1'b1);
    endtask

    task automatic test_length_limit();
        t_block blk;
        for (int b = 0; b < MAX_BLOCKS + 1; b++) begin
            for (int k = 0; k < 8; k++) begin
                blk[k] = random_char(0);
            end
            // length error must win over the invalid character
            if (b == 3) blk[5] = 8'h2A;
            send_block(blk, b == MAX_BLOCKS);
        end
    endtask

    task automatic test_validate_only();
        set_validate_mode(1'b1);
        send_id(2, 0);
        send_id(1, 50);
        set_validate_mode(1'b0);
    endtask

    task automatic test_random_ids(input int n_items);
        int sent;
        int len;
        int pick;
        int bad_pct;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) len = $urandom_range(1, 4);
            else if (pick < 90) len = $urandom_range(5, MAX_BLOCKS);
            else len = $urandom_range(MAX_BLOCKS + 1, 18);
            pick = $urandom_range(0, 99);
            if (pick < 70) bad_pct = 0;
            else if (pick < 90) bad_pct = 3;
            else bad_pct = 40;
            send_id(len, bad_pct);
            sent += len;
        end
    endtask

    task automatic test_backpressure();
        quiet = 1'b1;
        hold_req = HOLD_OFF_CYCLES;
        test_random_ids(40);
        quiet = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_validate_mode(1'b0);

        test_alphabet();
        test_bad_chars();
        test_length_limit();
        test_validate_only();

        test_random_ids(450);
        test_backpressure();
        set_validate_mode(1'b1);
        test_random_ids(300);
        set_validate_mode(1'b0);
        test_random_ids(200);

        // last stretch runs at full rate on both sides
        quiet = 1'b1;
        test_random_ids(150);

        wait_idle();
        if (expected_words.size() != 0) begin
            report_mismatch("words never received", DATA_W'(expected_words.size()), '0);
        end
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+design
design/sbd_pkg.sv
design/sbd_lane.sv
design/sbd_merge.sv
design/sorted_base32_block_decoder_core.sv
tb/sv/tb_top.sv
